// ===== src/kdlp_pkg.sv =====
`default_nettype none

package kdlp_pkg;

    localparam int KEY_COUNT  = 4;
    localparam int TIME_WIDTH = 32;
    localparam int CFG_WIDTH  = 16;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_CONSUME = 2'd1;
    localparam logic [1:0] REQ_INIT    = 2'd2;

    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(20);
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(1000);

    typedef logic [KEY_COUNT-1:0]  t_keys;
    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [CFG_WIDTH-1:0]  t_cfg;

    typedef struct packed {
        logic [1:0] req_type;
        t_time      now_time;
        t_keys      raw_keys;
    } t_item;

    typedef struct packed {
        t_keys stable_keys;
        t_keys down_events;
        t_keys up_events;
        t_keys long_events;
    } t_result;

    typedef struct packed {
        logic valid;
        logic index;
        t_cfg data;
    } t_cfg_write;

endpackage

`default_nettype wire

// ===== src/key_debounce_long_press.sv =====
// Debounce and long-press detection for a small bank of keys.
// The request channel (i_valid, o_stall) carries one word per call: a request
// type (sample, consume or init), the current tick and the raw key mask. A word
// is taken at a clock edge with i_valid high and o_stall low.
// Every request word gives exactly one result word on the result channel
// (o_valid, i_stall): the stable mask and the press, release and long-press
// event masks. Sample and init show the state after the update, consume shows
// the events before they clear.
// An accepted word goes from the input register through the state update to the
// result register, which drives o_valid; one word a cycle is sustained while
// the receiver does not stall, set by the single pass through the state update.
// When the receiver stalls, the result word holds; the input register still
// takes one more word, and o_stall rises only once both registers are full.
// The configuration channel (i_cfg_valid, o_cfg_ready) writes the debounce
// time (index 0) or the long-press time (index 1) when i_cfg_valid is high;
// it is always ready and is meant to be used only while the block is idle.
// Reset clears all key state and events, sets the times to 20 and 1000 ticks
// and empties both registers.
`default_nettype none

module key_debounce_long_press (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_req_type,
    input  wire kdlp_pkg::t_time      i_now_time,
    input  wire kdlp_pkg::t_keys      i_raw_keys,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output kdlp_pkg::t_keys           o_stable_keys,
    output kdlp_pkg::t_keys           o_down_events,
    output kdlp_pkg::t_keys           o_up_events,
    output kdlp_pkg::t_keys           o_long_events,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire kdlp_pkg::t_cfg       i_cfg_data
);
    import kdlp_pkg::*;

    logic       out_free;
    logic       advance;
    t_item      item;
    t_result    next_result;
    t_result    result;
    t_cfg_write cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg         = '{i_cfg_valid, i_cfg_index, i_cfg_data};

    kdlp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_now_time (i_now_time),
        .i_raw_keys (i_raw_keys),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_item     (item)
    );

    kdlp_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_item    (item),
        .o_result  (next_result)
    );

    kdlp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_result  (next_result),
        .o_free    (out_free),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (result)
    );

    assign o_stable_keys = result.stable_keys;
    assign o_down_events = result.down_events;
    assign o_up_events   = result.up_events;
    assign o_long_events = result.long_events;

endmodule

`default_nettype wire

// ===== src/kdlp_in_stage.sv =====
`default_nettype none

module kdlp_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [1:0]     i_req_type,
    input  wire kdlp_pkg::t_time i_now_time,
    input  wire kdlp_pkg::t_keys i_raw_keys,
    input  wire logic           i_out_free,
    output logic                o_advance,
    output kdlp_pkg::t_item     o_item
);
    import kdlp_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_stall   = r_valid && !i_out_free;
    assign o_advance = r_valid && i_out_free;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.req_type <= i_req_type;
            r_item.now_time <= i_now_time;
            r_item.raw_keys <= i_raw_keys;
        end
    end

endmodule

`default_nettype wire

// ===== src/kdlp_state.sv =====
`default_nettype none

module kdlp_state (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kdlp_pkg::t_cfg_write i_cfg,
    input  wire logic                i_advance,
    input  wire kdlp_pkg::t_item     i_item,
    output kdlp_pkg::t_result        o_result
);
    import kdlp_pkg::*;

    t_cfg  r_debounce_time;
    t_cfg  r_long_press_time;
    t_keys r_stable;
    t_keys r_last_raw;
    t_time r_change_time;
    t_time r_press_start [KEY_COUNT];
    t_keys r_reported;
    t_keys r_down;
    t_keys r_up;
    t_keys r_long;

    t_keys n_stable;
    t_keys n_last_raw;
    t_time n_change_time;
    t_time n_press_start [KEY_COUNT];
    t_keys n_reported;
    t_keys n_down;
    t_keys n_up;
    t_keys n_long;

    t_keys changed;
    t_time hold_time;
    t_time press_time;

    always_comb begin
        n_stable      = r_stable;
        n_last_raw    = r_last_raw;
        n_change_time = r_change_time;
        n_press_start = r_press_start;
        n_reported    = r_reported;
        n_down        = r_down;
        n_up          = r_up;
        n_long        = r_long;
        changed       = r_stable ^ i_item.raw_keys;
        hold_time     = '0;
        press_time    = '0;
        o_result      = '{r_stable, r_down, r_up, r_long};
        unique case (i_item.req_type)
            REQ_SAMPLE: begin
                if (i_item.raw_keys != r_last_raw) begin
                    n_last_raw    = i_item.raw_keys;
                    n_change_time = i_item.now_time;
                end
                hold_time = i_item.now_time - n_change_time;
                if ({{CFG_WIDTH{1'b0}}, hold_time} >=
                    {{TIME_WIDTH{1'b0}}, r_debounce_time}) begin
                    n_down     = r_down | (changed & i_item.raw_keys);
                    n_up       = r_up | (changed & ~i_item.raw_keys);
                    n_stable   = i_item.raw_keys;
                    n_reported = r_reported & ~changed;
                    for (int k = 0; k < KEY_COUNT; k++) begin
                        if (changed[k] && i_item.raw_keys[k]) begin
                            n_press_start[k] = i_item.now_time;
                        end
                    end
                end
                for (int k = 0; k < KEY_COUNT; k++) begin
                    press_time = i_item.now_time - n_press_start[k];
                    if (n_stable[k] && !n_reported[k] &&
                        {{CFG_WIDTH{1'b0}}, press_time} >=
                        {{TIME_WIDTH{1'b0}}, r_long_press_time}) begin
                        n_long[k]     = 1'b1;
                        n_reported[k] = 1'b1;
                    end
                end
                o_result = '{n_stable, n_down, n_up, n_long};
            end
            REQ_CONSUME: begin
                n_down = '0;
                n_up   = '0;
                n_long = '0;
            end
            REQ_INIT: begin
                for (int k = 0; k < KEY_COUNT; k++) begin
                    n_press_start[k] = '0;
                end
                n_last_raw    = i_item.raw_keys;
                n_stable      = i_item.raw_keys;
                n_change_time = i_item.now_time;
                n_down        = '0;
                n_up          = '0;
                n_long        = '0;
                n_reported    = '0;
                o_result      = '{n_stable, n_down, n_up, n_long};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= DEBOUNCE_RESET;
            r_long_press_time <= LONG_PRESS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DEBOUNCE:   r_debounce_time   <= i_cfg.data;
                CFG_LONG_PRESS: r_long_press_time <= i_cfg.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= '0;
            r_last_raw    <= '0;
            r_change_time <= '0;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_press_start[k] <= '0;
            end
            r_reported    <= '0;
            r_down        <= '0;
            r_up          <= '0;
            r_long        <= '0;
        end else if (i_advance) begin
            r_stable      <= n_stable;
            r_last_raw    <= n_last_raw;
            r_change_time <= n_change_time;
            r_press_start <= n_press_start;
            r_reported    <= n_reported;
            r_down        <= n_down;
            r_up          <= n_up;
            r_long        <= n_long;
        end
    end

endmodule

`default_nettype wire

// ===== src/kdlp_out_stage.sv =====
`default_nettype none

module kdlp_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire kdlp_pkg::t_result i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output kdlp_pkg::t_result     o_result
);
    import kdlp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_advance) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== src/kdlp_checker.sv =====
`default_nettype none

module kdlp_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_valid,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire kdlp_pkg::t_keys o_stable_keys,
    input wire kdlp_pkg::t_keys o_down_events,
    input wire kdlp_pkg::t_keys o_up_events,
    input wire kdlp_pkg::t_keys o_long_events
);
    import kdlp_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result register can move");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##1 o_valid)
        else $error("accepted word gave no result in time");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_stable_keys) &&
            $stable(o_down_events) && $stable(o_up_events) && $stable(o_long_events)))
        else $error("stalled result word changed");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_stable_keys (o_stable_keys),
    .o_down_events (o_down_events),
    .o_up_events   (o_up_events),
    .o_long_events (o_long_events)
);

`default_nettype wire
